// ===== sv/tdc_hit_time_histogram_core_macros.svh =====
// Assertion macros for the checker file.
`ifndef TDC_HIT_TIME_HISTOGRAM_CORE_MACROS_SVH
`define TDC_HIT_TIME_HISTOGRAM_CORE_MACROS_SVH
// Clocked implication checked outside reset.
`define TDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Clocked next-cycle implication checked outside reset.
`define TDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/tdc_pkg.sv =====
// Package with shared constants and types for the histogram core.
package tdc_pkg;
  localparam int CHANNELS_DEF = 42;
  localparam int BINS_DEF = 16;
  localparam int BIN_BITS_DEF = 8;
  localparam logic [31:0] END_MARK = 32'hffff_ffff;
  localparam logic [9:0] COARSE_SCALE_RST = 10'd254;
  localparam logic [3:0] FINE_SCALE_RST = 4'd3;
  localparam logic [15:0] BIN_WIDTH_RST = 16'd63;
  localparam logic [5:0] CHANNELS_IN_USE_RST = 6'd42;
  localparam int TIME_W = 26;
  localparam int QUO_W = 5;

  typedef enum logic [1:0] {
    CFG_COARSE_SCALE = 2'd0,
    CFG_FINE_SCALE = 2'd1,
    CFG_BIN_WIDTH = 2'd2,
    CFG_CHANNELS_IN_USE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_UPDATE,
    ST_CHECK,
    ST_OUT,
    ST_DUP
  } state_t;

  typedef struct packed {
    logic load;
    logic mem_read;
    logic div_start;
    logic hit_write;
    logic end_write;
    logic out_load;
    logic out_clear_total;
  } cmd_t;

  typedef struct packed {
    logic in_use;
    logic is_end;
    logic div_done;
    logic idx_ok;
    logic already_ended;
    logic all_ended;
  } sts_t;
endpackage

// ===== sv/tdc_datapath.sv =====
// Datapath: time computation, bin divider, histogram memory and total accumulator.
module tdc_datapath #(
  parameter int CHANNELS = tdc_pkg::CHANNELS_DEF,
  parameter int BINS = tdc_pkg::BINS_DEF,
  parameter int BIN_BITS = tdc_pkg::BIN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_en,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_data,
  input  logic [5:0]                 in_channel,
  input  logic [31:0]                in_word,
  input  tdc_pkg::cmd_t              cmd,
  output tdc_pkg::sts_t              sts,
  output logic [63:0]                bins_low,
  output logic [63:0]                bins_high,
  output logic                       status
);
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = 2 * CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TW = tdc_pkg::TIME_W;
  localparam logic [7:0] BIN_MAX = 8'((1 << BIN_BITS) - 1);

  logic [9:0]  coarse_scale_r;
  logic [3:0]  fine_scale_r;
  logic [15:0] bin_width_r;
  logic [5:0]  ch_use_r;
  logic [6:0]  n_eff;

  logic [5:0]  ch_r;
  logic [31:0] word_r;
  logic [63:0] mem [DEPTH];
  logic [ADDR_W-1:0] lo_addr;
  logic [ADDR_W-1:0] hi_addr;
  logic [CHANNELS-1:0] hist_vld_r;
  logic        rd_vld_r;
  logic [63:0] rd_lo_r, rd_hi_r;
  logic [63:0] rd_lo_m, rd_hi_m;
  logic [63:0] hit_lo, hit_hi;
  logic [63:0] tot_lo_r, tot_hi_r;
  logic [CHANNELS-1:0] ended_r;

  logic [tdc_pkg::TIME_W-1:0] rem_r;
  logic [tdc_pkg::TIME_W-1:0] t_comb;
  logic [tdc_pkg::QUO_W-1:0]  quo_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] part_r;
  logic [16:0] part_nxt;
  logic        big_r;
  logic [63:0] out_lo_r, out_hi_r;
  logic        status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_scale_r <= tdc_pkg::COARSE_SCALE_RST;
      fine_scale_r <= tdc_pkg::FINE_SCALE_RST;
      bin_width_r <= tdc_pkg::BIN_WIDTH_RST;
      ch_use_r <= tdc_pkg::CHANNELS_IN_USE_RST;
    end else if (cfg_en) begin
      case (tdc_pkg::cfg_idx_t'(cfg_index))
        tdc_pkg::CFG_COARSE_SCALE: coarse_scale_r <= cfg_data[9:0];
        tdc_pkg::CFG_FINE_SCALE: fine_scale_r <= cfg_data[3:0];
        tdc_pkg::CFG_BIN_WIDTH: bin_width_r <= cfg_data;
        tdc_pkg::CFG_CHANNELS_IN_USE: ch_use_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = {1'b0, ch_use_r};
    if (n_eff == 7'd0) n_eff = 7'd1;
    if (n_eff > 7'(CHANNELS)) n_eff = 7'(CHANNELS);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r <= in_channel;
      word_r <= in_word;
    end
  end

  always_comb begin
    t_comb = TW'(word_r[23:9]) * TW'(coarse_scale_r) + TW'(word_r[8:0]) * TW'(fine_scale_r);
  end

  assign lo_addr = ADDR_W'({ch_r[CH_W-1:0], 1'b0});
  assign hi_addr = ADDR_W'({ch_r[CH_W-1:0], 1'b1});

  // A channel whose valid flag is clear reads as an empty histogram.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (cmd.hit_write) begin
      hist_vld_r[ch_r[CH_W-1:0]] <= 1'b1;
    end else if (cmd.end_write) begin
      hist_vld_r[ch_r[CH_W-1:0]] <= 1'b0;
    end
  end

  assign rd_lo_m = rd_vld_r ? rd_lo_r : '0;
  assign rd_hi_m = rd_vld_r ? rd_hi_r : '0;

  always_comb begin
    hit_lo = rd_lo_m;
    hit_hi = rd_hi_m;
    for (int i = 0; i < 8; i++) begin
      if (quo_r == 5'(i) && rd_lo_m[i*8 +: 8] < BIN_MAX)
        hit_lo[i*8 +: 8] = rd_lo_m[i*8 +: 8] + 8'd1;
      if (quo_r == 5'(i + 8) && rd_hi_m[i*8 +: 8] < BIN_MAX)
        hit_hi[i*8 +: 8] = rd_hi_m[i*8 +: 8] + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_lo_r <= mem[lo_addr];
      rd_hi_r <= mem[hi_addr];
      rd_vld_r <= hist_vld_r[ch_r[CH_W-1:0]];
    end
    if (cmd.hit_write) begin
      mem[lo_addr] <= hit_lo;
      mem[hi_addr] <= hit_hi;
    end
  end

  // Restoring divider: one quotient bit per cycle; only the low five bits are kept, a bit shifted out sets big_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r <= 5'(tdc_pkg::TIME_W);
    end else if (busy_r) begin
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
      cnt_r <= cnt_r - 5'd1;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_comb begin
    part_nxt = {part_r[15:0], rem_r[tdc_pkg::TIME_W-1]};
  end
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= t_comb;
      part_r <= '0;
      quo_r <= '0;
      big_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= {rem_r[tdc_pkg::TIME_W-2:0], 1'b0};
      if (part_nxt >= {1'b0, bin_width_r}) begin
        part_r <= part_nxt - {1'b0, bin_width_r};
        if (quo_r[tdc_pkg::QUO_W-1]) big_r <= 1'b1;
        quo_r <= {quo_r[tdc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        part_r <= part_nxt;
        if (quo_r[tdc_pkg::QUO_W-1]) big_r <= 1'b1;
        quo_r <= {quo_r[tdc_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_lo_r <= '0;
      tot_hi_r <= '0;
      ended_r <= '0;
    end else if (cmd.end_write) begin
      for (int i = 0; i < 8; i++) begin
        tot_lo_r[i*8 +: 8] <= (9'(tot_lo_r[i*8 +: 8]) + 9'(rd_lo_m[i*8 +: 8]) > 9'(BIN_MAX))
                              ? BIN_MAX : tot_lo_r[i*8 +: 8] + rd_lo_m[i*8 +: 8];
        tot_hi_r[i*8 +: 8] <= (9'(tot_hi_r[i*8 +: 8]) + 9'(rd_hi_m[i*8 +: 8]) > 9'(BIN_MAX))
                              ? BIN_MAX : tot_hi_r[i*8 +: 8] + rd_hi_m[i*8 +: 8];
      end
      ended_r[ch_r[CH_W-1:0]] <= 1'b1;
    end else if (cmd.out_clear_total) begin
      tot_lo_r <= '0;
      tot_hi_r <= '0;
      ended_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= ~cmd.out_clear_total;
      out_lo_r <= cmd.out_clear_total ? tot_lo_r : '0;
      out_hi_r <= cmd.out_clear_total ? tot_hi_r : '0;
    end
  end

  always_comb begin
    sts.in_use = {1'b0, ch_r} < n_eff;
    sts.is_end = word_r == tdc_pkg::END_MARK;
    sts.div_done = done_r;
    sts.idx_ok = (bin_width_r != 16'd0) && !big_r && (quo_r < 5'(BINS));
    sts.already_ended = ended_r[ch_r[CH_W-1:0]];
    sts.all_ended = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (7'(i) < n_eff && !ended_r[i]) sts.all_ended = 1'b0;
    end
  end

  assign bins_low = out_lo_r;
  assign bins_high = out_hi_r;
  assign status = status_r;
endmodule

// ===== sv/tdc_ctrl.sv =====
// Controller state machine sequencing one word through the datapath.
module tdc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  tdc_pkg::sts_t sts,
  output tdc_pkg::cmd_t cmd
);
  tdc_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdc_pkg::ST_IDLE: if (in_valid) state_nxt = tdc_pkg::ST_READ;
      tdc_pkg::ST_READ: begin
        if (!sts.in_use) state_nxt = tdc_pkg::ST_IDLE;
        else if (sts.is_end) state_nxt = sts.already_ended ? tdc_pkg::ST_DUP
                                                          : tdc_pkg::ST_UPDATE;
        else state_nxt = tdc_pkg::ST_DIV;
      end
      tdc_pkg::ST_DIV: if (sts.div_done) state_nxt = tdc_pkg::ST_IDLE;
      tdc_pkg::ST_UPDATE: state_nxt = tdc_pkg::ST_CHECK;
      tdc_pkg::ST_CHECK: state_nxt = sts.all_ended ? tdc_pkg::ST_OUT : tdc_pkg::ST_IDLE;
      tdc_pkg::ST_OUT: if (!out_valid_r || !out_stall) state_nxt = tdc_pkg::ST_IDLE;
      tdc_pkg::ST_DUP: if (!out_valid_r || !out_stall) state_nxt = tdc_pkg::ST_IDLE;
      default: state_nxt = tdc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      tdc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      tdc_pkg::ST_READ: begin
        cmd.mem_read = 1'b1;
        cmd.div_start = sts.in_use && !sts.is_end;
      end
      tdc_pkg::ST_DIV: cmd.hit_write = sts.div_done && sts.idx_ok;
      tdc_pkg::ST_UPDATE: cmd.end_write = 1'b1;
      tdc_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          cmd.out_clear_total = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      tdc_pkg::ST_DUP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
endmodule

// ===== sv/tdc_hit_time_histogram_core.sv =====
// Top level of the TDC hit-time histogram core.
// A hit word holds the input through load, memory read, 26 divider steps and write.
// An end marker holds it through load, memory read, total update and check; one that completes
// the event then loads its result word and frees the input, as does a repeated one after the read.
// A word on an unused channel is dropped after the memory read; a waiting result word only delays the next one.
// rst_n is synchronous, active low; it restores register defaults and empties all histograms.
module tdc_hit_time_histogram_core #(
  parameter int CHANNELS = tdc_pkg::CHANNELS_DEF,
  parameter int BINS = tdc_pkg::BINS_DEF,
  parameter int BIN_BITS = tdc_pkg::BIN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_channel,
  input  logic [31:0] in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bins_low,
  output logic [63:0] out_bins_high,
  output logic        out_status
);
  tdc_pkg::cmd_t cmd;
  tdc_pkg::sts_t sts;

  tdc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  tdc_datapath #(.CHANNELS(CHANNELS), .BINS(BINS), .BIN_BITS(BIN_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_en(cfg_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_channel(in_channel), .in_word(in_word),
    .cmd(cmd), .sts(sts), .bins_low(out_bins_low), .bins_high(out_bins_high),
    .status(out_status)
  );
endmodule

// ===== sv/tdc_checker.sv =====
// Port-level checker for the histogram core and its bind.
`include "tdc_hit_time_histogram_core_macros.svh"
module tdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_bins_low,
  input logic        out_status
);
  `TDC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result word dropped")
  `TDC_ASSERT_IMP(a_rep_zero, clk, rst_n, out_valid && out_status, out_bins_low == 64'd0, "repeat flag with data")
  `TDC_ASSERT_NXT(a_one_at_time, clk, rst_n, in_valid && !in_stall, in_stall, "second word taken too early")
endmodule

bind tdc_hit_time_histogram_core tdc_checker u_tdc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_bins_low(out_bins_low),
  .out_status(out_status)
);
